// File: src/ptet_pkg.sv
`timescale 1ns / 1ps

package ptet_pkg;

  // Field widths of the item channels
  localparam int ACTION_W = 3;
  localparam int WEEK_W = 4;
  localparam int PLAYER_W = 5;
  localparam int STATUS_W = 2;

  // Configuration port and register widths
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 16;
  localparam int TENURE_W = 16;
  localparam int WEEKS_CFG_W = 5;
  localparam int PLAYERS_CFG_W = 6;

  // Width used for range compares (holds the largest player count)
  localparam int LIM_W = 9;

  // Random source
  localparam int LFSR_W = 32;
  localparam logic [LFSR_W-1:0] LFSR_SEED = 32'h2545_F491;
  localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

  // Remainder unit: quotient bits retired per cycle
  localparam int MOD_STEP = 4;

  // Parameter defaults
  localparam int MAX_WEEKS_DEF = 16;
  localparam int MAX_PLAYERS_DEF = 32;
  localparam int COUNT_WIDTH_DEF = 32;

  // Register reset values
  localparam logic [TENURE_W-1:0] TENURE_LOW_RST = 16'd4;
  localparam logic [TENURE_W-1:0] TENURE_HIGH_RST = 16'd100;
  localparam logic [WEEKS_CFG_W-1:0] WEEKS_RST = 5'd16;
  localparam logic [PLAYERS_CFG_W-1:0] PLAYERS_RST = 6'd32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ADD      = 3'd0,
    ACT_QUERY    = 3'd1,
    ACT_CLR_WEEK = 3'd2,
    ACT_CLR_ALL  = 3'd3,
    ACT_TICK     = 3'd4
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_WEEK    = 2'd1,
    ST_PLAYER  = 2'd2,
    ST_TENURE  = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TENURE_LOW  = 2'd0,
    CFG_TENURE_HIGH = 2'd1,
    CFG_WEEKS       = 2'd2,
    CFG_PLAYERS     = 2'd3
  } cfg_idx_e;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_item;
    logic read;
    logic add_start;
    logic add_write;
    logic latch_tabu;
    logic sweep_week;
    logic sweep_all;
    logic sweep_step;
    logic tick;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    action_e act;
    status_e status;
    logic    div_busy;
    logic    sweep_last;
  } sts_t;

endpackage

// File: src/ptet_req_if.sv
`timescale 1ns / 1ps

interface ptet_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptet_pkg::ACTION_W-1:0] action;
  logic [ptet_pkg::WEEK_W-1:0]   week;
  logic [ptet_pkg::PLAYER_W-1:0] player_a;
  logic [ptet_pkg::PLAYER_W-1:0] player_b;

  modport source (output valid, output action, output week, output player_a,
                  output player_b, input ready);
  modport sink (input valid, input action, input week, input player_a,
                input player_b, output ready);
endinterface

// File: src/ptet_rsp_if.sv
`timescale 1ns / 1ps

interface ptet_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          pair_is_tabu;
  logic [ptet_pkg::STATUS_W-1:0] status;

  modport source (output valid, output pair_is_tabu, output status, input ready);
  modport sink (input valid, input pair_is_tabu, input status, output ready);
endinterface

// File: src/ptet_mod.sv
`timescale 1ns / 1ps

module ptet_mod (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ptet_pkg::LFSR_W-1:0]   dividend_i,
  input  logic [ptet_pkg::TENURE_W-1:0] divisor_i,
  output logic                          busy_o,
  output logic [ptet_pkg::TENURE_W-1:0] rem_o
);

  localparam int CYCLES = ptet_pkg::LFSR_W / ptet_pkg::MOD_STEP;
  localparam int CNT_W = (CYCLES > 1) ? $clog2(CYCLES) : 1;
  localparam int TW = ptet_pkg::TENURE_W;

  logic [ptet_pkg::LFSR_W-1:0] num_q, num_d;
  logic [TW-1:0]               rem_q, rem_d;
  logic [TW-1:0]               div_q;
  logic [CNT_W-1:0]            cnt_q;
  logic                        busy_q;
  logic [TW:0]                 trial;

  // Retire several quotient bits per cycle, restoring form
  always_comb begin
    num_d = num_q;
    rem_d = rem_q;
    trial = '0;
    for (int k = 0; k < ptet_pkg::MOD_STEP; k++) begin
      trial = {rem_d, num_d[ptet_pkg::LFSR_W-1]};
      num_d = {num_d[ptet_pkg::LFSR_W-2:0], 1'b0};
      if (trial >= {1'b0, div_q}) begin
        trial = trial - {1'b0, div_q};
      end
      rem_d = trial[TW-1:0];
    end
  end

  // Sequence the passes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == CNT_W'(CYCLES - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Hold operands and partial remainder
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o = busy_q;
  // A zero spread draws zero
  assign rem_o  = (div_q == '0) ? '0 : rem_q;

endmodule

// File: src/ptet_dp.sv
`timescale 1ns / 1ps

module ptet_dp #(
  parameter int MAX_WEEKS   = ptet_pkg::MAX_WEEKS_DEF,
  parameter int MAX_PLAYERS = ptet_pkg::MAX_PLAYERS_DEF,
  parameter int COUNT_WIDTH = ptet_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ptet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptet_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [ptet_pkg::ACTION_W-1:0]   item_action_i,
  input  logic [ptet_pkg::WEEK_W-1:0]     item_week_i,
  input  logic [ptet_pkg::PLAYER_W-1:0]   item_player_a_i,
  input  logic [ptet_pkg::PLAYER_W-1:0]   item_player_b_i,
  input  ptet_pkg::cmd_t                  cmd_i,
  output ptet_pkg::sts_t                  sts_o,
  output logic                            tabu_o,
  output logic [ptet_pkg::STATUS_W-1:0]   status_o
);

  localparam int WEEK_AW = (MAX_WEEKS > 1) ? $clog2(MAX_WEEKS) : 1;
  localparam int PAW = $clog2(MAX_PLAYERS);
  localparam int WEEK_XW = (WEEK_AW > ptet_pkg::WEEK_W) ? WEEK_AW : ptet_pkg::WEEK_W;
  localparam int PLAYER_XW = (PAW > ptet_pkg::PLAYER_W) ? PAW : ptet_pkg::PLAYER_W;
  localparam int ROW_AW = WEEK_AW + PAW;
  localparam int EXP_AW = ROW_AW + PAW;
  localparam int ROWS = 1 << ROW_AW;
  localparam int ROW_W = 1 << PAW;
  localparam int EXP_DEPTH = 1 << EXP_AW;
  localparam int LW = ptet_pkg::LIM_W;
  localparam int TW = ptet_pkg::TENURE_W;

  // Configuration registers
  logic [TW-1:0]                      tenure_low_q, tenure_high_q;
  logic [ptet_pkg::WEEKS_CFG_W-1:0]   weeks_q;
  logic [ptet_pkg::PLAYERS_CFG_W-1:0] players_q;

  // Item registers
  logic [ptet_pkg::ACTION_W-1:0] act_q;
  logic [ptet_pkg::WEEK_W-1:0]   week_q;
  logic [ptet_pkg::PLAYER_W-1:0] pa_q, pb_q;

  // Block state
  logic [COUNT_WIDTH-1:0]        iter_q;
  logic [ptet_pkg::LFSR_W-1:0]   lfsr_q, lfsr_nx;
  logic [ROW_AW-1:0]             sweep_addr_q;
  logic                          sweep_all_q;
  logic                          tabu_q;
  logic                          out_tabu_q;
  logic [ptet_pkg::STATUS_W-1:0] out_status_q;

  // Memories and their read registers
  logic [ROW_W-1:0]       valid_mem [ROWS];
  logic [COUNT_WIDTH-1:0] exp_mem [EXP_DEPTH];
  logic [ROW_W-1:0]       row_rd_q;
  logic [COUNT_WIDTH-1:0] exp_rd_q;

  // Decode
  ptet_pkg::action_e      act;
  ptet_pkg::status_e      status;
  logic                   week_ok, player_ok, tenure_ok;
  logic [ptet_pkg::PLAYER_W-1:0] lo, hi;
  logic [WEEK_XW-1:0]     week_x;
  logic [PLAYER_XW-1:0]   lo_x, hi_x;
  logic [WEEK_AW-1:0]     week_i;
  logic [PAW-1:0]         lo_i, hi_i;
  logic [ROW_AW-1:0]      row_addr;
  logic [EXP_AW-1:0]      exp_addr;
  logic [ROW_W-1:0]       row_bit;
  logic [TW-1:0]          spread;
  logic [TW-1:0]          draw;
  logic                   div_busy;
  logic [COUNT_WIDTH-1:0] expiry_sum;

  function automatic logic [ptet_pkg::LFSR_W-1:0] lfsr_next(
    input logic [ptet_pkg::LFSR_W-1:0] s
  );
    logic [ptet_pkg::LFSR_W-1:0] nx;
    nx = s >> 1;
    if (s[0]) begin
      nx = nx ^ ptet_pkg::LFSR_TAPS;
    end
    return nx;
  endfunction

  // Range checks against the smaller of register and capacity
  assign week_ok = (LW'(week_q) < LW'(weeks_q)) && (LW'(week_q) < LW'(MAX_WEEKS));
  assign player_ok = (LW'(pa_q) < LW'(players_q)) && (LW'(pa_q) < LW'(MAX_PLAYERS)) &&
                     (LW'(pb_q) < LW'(players_q)) && (LW'(pb_q) < LW'(MAX_PLAYERS));
  assign tenure_ok = (tenure_low_q <= tenure_high_q);

  assign act = ptet_pkg::action_e'(act_q);

  // Pick the status code in check order
  always_comb begin
    status = ptet_pkg::ST_OK;
    case (act)
      ptet_pkg::ACT_ADD, ptet_pkg::ACT_QUERY: begin
        if (!week_ok) begin
          status = ptet_pkg::ST_WEEK;
        end else if (!player_ok) begin
          status = ptet_pkg::ST_PLAYER;
        end else if ((act == ptet_pkg::ACT_ADD) && !tenure_ok) begin
          status = ptet_pkg::ST_TENURE;
        end
      end
      ptet_pkg::ACT_CLR_WEEK: begin
        if (!week_ok) begin
          status = ptet_pkg::ST_WEEK;
        end
      end
      default: status = ptet_pkg::ST_OK;
    endcase
  end

  // Order the pair and form table addresses
  assign lo = (pa_q < pb_q) ? pa_q : pb_q;
  assign hi = (pa_q < pb_q) ? pb_q : pa_q;
  assign week_x = WEEK_XW'(week_q);
  assign lo_x = PLAYER_XW'(lo);
  assign hi_x = PLAYER_XW'(hi);
  assign week_i = week_x[WEEK_AW-1:0];
  assign lo_i = lo_x[PAW-1:0];
  assign hi_i = hi_x[PAW-1:0];
  assign row_addr = {week_i, lo_i};
  assign exp_addr = {week_i, lo_i, hi_i};
  assign row_bit = ROW_W'(1) << hi_i;

  assign spread = tenure_high_q - tenure_low_q;
  assign lfsr_nx = lfsr_next(lfsr_q);
  assign expiry_sum = iter_q + COUNT_WIDTH'(tenure_low_q) + COUNT_WIDTH'(draw);

  ptet_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.add_start),
    .dividend_i (lfsr_nx),
    .divisor_i  (spread),
    .busy_o     (div_busy),
    .rem_o      (draw)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tenure_low_q  <= ptet_pkg::TENURE_LOW_RST;
      tenure_high_q <= ptet_pkg::TENURE_HIGH_RST;
      weeks_q       <= ptet_pkg::WEEKS_RST;
      players_q     <= ptet_pkg::PLAYERS_RST;
    end else if (cfg_we_i) begin
      case (ptet_pkg::cfg_idx_e'(cfg_idx_i))
        ptet_pkg::CFG_TENURE_LOW:  tenure_low_q  <= cfg_data_i[TW-1:0];
        ptet_pkg::CFG_TENURE_HIGH: tenure_high_q <= cfg_data_i[TW-1:0];
        ptet_pkg::CFG_WEEKS:       weeks_q   <= cfg_data_i[ptet_pkg::WEEKS_CFG_W-1:0];
        ptet_pkg::CFG_PLAYERS:     players_q <= cfg_data_i[ptet_pkg::PLAYERS_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  // Advance iteration, random source and sweep pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q       <= '0;
      lfsr_q       <= ptet_pkg::LFSR_SEED;
      sweep_addr_q <= '0;
      sweep_all_q  <= 1'b1;
    end else begin
      if (cmd_i.tick) begin
        iter_q <= iter_q + COUNT_WIDTH'(1);
      end
      if (cmd_i.add_start) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.sweep_week) begin
        sweep_addr_q <= {week_i, PAW'(0)};
        sweep_all_q  <= 1'b0;
      end else if (cmd_i.sweep_all) begin
        sweep_addr_q <= '0;
        sweep_all_q  <= 1'b1;
      end else if (cmd_i.sweep_step) begin
        sweep_addr_q <= sweep_addr_q + ROW_AW'(1);
      end
    end
  end

  // Capture the item and build the result
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      act_q  <= item_action_i;
      week_q <= item_week_i;
      pa_q   <= item_player_a_i;
      pb_q   <= item_player_b_i;
      tabu_q <= 1'b0;
    end else if (cmd_i.latch_tabu) begin
      tabu_q <= row_rd_q[hi_i] && (iter_q < exp_rd_q);
    end
    if (cmd_i.out_load) begin
      out_tabu_q   <= tabu_q;
      out_status_q <= status;
    end
  end

  // Valid rows: clear by sweep, set on add
  always_ff @(posedge clk_i) begin
    if (cmd_i.sweep_step) begin
      valid_mem[sweep_addr_q] <= '0;
    end else if (cmd_i.add_write) begin
      valid_mem[row_addr] <= row_rd_q | row_bit;
    end
    if (cmd_i.read) begin
      row_rd_q <= valid_mem[row_addr];
    end
  end

  // Expiry table
  always_ff @(posedge clk_i) begin
    if (cmd_i.add_write) begin
      exp_mem[exp_addr] <= expiry_sum;
    end
    if (cmd_i.read) begin
      exp_rd_q <= exp_mem[exp_addr];
    end
  end

  assign sts_o.act        = act;
  assign sts_o.status     = status;
  assign sts_o.div_busy   = div_busy;
  assign sts_o.sweep_last = sweep_all_q ? (&sweep_addr_q) : (&sweep_addr_q[PAW-1:0]);

  assign tabu_o   = out_tabu_q;
  assign status_o = out_status_q;

endmodule

// File: src/ptet_ctrl.sv
`timescale 1ns / 1ps

module ptet_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  input  ptet_pkg::sts_t sts_i,
  output ptet_pkg::cmd_t cmd_o
);

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DECODE,
    S_DIV,
    S_READ,
    S_CLEAR,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   ok;

  assign ok = (sts_i.status == ptet_pkg::ST_OK);

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_INIT: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_DONE;
        case (sts_i.act)
          ptet_pkg::ACT_ADD: begin
            if (ok) begin
              cmd_o.read      = 1'b1;
              cmd_o.add_start = 1'b1;
              state_d = S_DIV;
            end
          end
          ptet_pkg::ACT_QUERY: begin
            if (ok) begin
              cmd_o.read = 1'b1;
              state_d = S_READ;
            end
          end
          ptet_pkg::ACT_CLR_WEEK: begin
            if (ok) begin
              cmd_o.sweep_week = 1'b1;
              state_d = S_CLEAR;
            end
          end
          ptet_pkg::ACT_CLR_ALL: begin
            cmd_o.sweep_all = 1'b1;
            state_d = S_CLEAR;
          end
          ptet_pkg::ACT_TICK: cmd_o.tick = 1'b1;
          default: state_d = S_DONE;
        endcase
      end
      S_DIV: begin
        if (!sts_i.div_busy) begin
          cmd_o.add_write = 1'b1;
          state_d = S_DONE;
        end
      end
      S_READ: begin
        cmd_o.latch_tabu = 1'b1;
        state_d = S_DONE;
      end
      S_CLEAR: begin
        cmd_o.sweep_step = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Hold the output item until taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

// File: src/pair_tabu_expiry_table.sv
`timescale 1ns / 1ps

// Tabu memory for local search: one expiry count per week and unordered player pair,
// held in a direct-mapped table with one valid row per (week, smaller player), all
// in RAM. After reset a clearing pass writes every valid row, one row a cycle, over
// MAX_WEEKS rounded up to a power of two (at least 2) times 2**clog2(MAX_PLAYERS)
// rows (512 at the defaults); no item is accepted during it, configuration writes
// are taken at any time. One item is worked at a time, and the next one may enter
// while the last result still waits in the output register. Per item: a tick, an
// unused action or an item with an error status goes from decode to done, a query
// adds a registered table read, an add waits while an iterative remainder unit draws
// the random tenure part, four bits a cycle over the 32-bit random word, a week clear
// sweeps 2**clog2(MAX_PLAYERS) rows and a full clear all rows of the clearing pass,
// both sweeping the valid RAM one row a cycle.
module pair_tabu_expiry_table #(
  parameter int MAX_WEEKS   = ptet_pkg::MAX_WEEKS_DEF,
  parameter int MAX_PLAYERS = ptet_pkg::MAX_PLAYERS_DEF,
  parameter int COUNT_WIDTH = ptet_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  ptet_req_if.sink                        req_i,
  ptet_rsp_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [ptet_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ptet_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  ptet_pkg::cmd_t cmd;
  ptet_pkg::sts_t sts;

  ptet_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (req_i.valid),
    .in_ready_o  (req_i.ready),
    .out_valid_o (rsp_o.valid),
    .out_ready_i (rsp_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ptet_dp #(
    .MAX_WEEKS   (MAX_WEEKS),
    .MAX_PLAYERS (MAX_PLAYERS),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .item_action_i   (req_i.action),
    .item_week_i     (req_i.week),
    .item_player_a_i (req_i.player_a),
    .item_player_b_i (req_i.player_b),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .tabu_o          (rsp_o.pair_is_tabu),
    .status_o        (rsp_o.status)
  );

  // One item in flight: no second accept right after one
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_i.valid && req_i.ready) |=> !req_i.ready)
    else $error("item accepted while previous item still at work");

  // A finished item never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> (!rsp_o.valid || rsp_o.ready))
    else $error("result register overwritten before it was taken");

  // Sweep and add never share the valid RAM write port
  a_write_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.sweep_step && cmd.add_write))
    else $error("sweep and add write valid RAM in the same cycle");

  // Remainder unit is idle whenever the block can take an item
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.ready |-> !sts.div_busy)
    else $error("remainder unit busy while block is ready");

endmodule

// File: test/ptet_tabu_checker.sv
`timescale 1ns / 1ps

// Watches both item channels and the register port, keeps a private copy of
// the tabu table, and checks every result against the oldest prediction.
module ptet_tabu_checker
  import ptet_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  ptet_req_if                   req,
  ptet_rsp_if                   rsp,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int unsigned           errors_o,
  output int unsigned           pending_o,
  output int unsigned           checked_o,
  output int unsigned           hits_o,
  output int unsigned           rejects_o
);

  localparam int WEEKS       = MAX_WEEKS_DEF;
  localparam int PLAYERS     = MAX_PLAYERS_DEF;
  localparam int WEEK_SPAN   = PLAYERS * PLAYERS;
  localparam int TABLE_DEPTH = WEEKS * WEEK_SPAN;

  typedef struct packed {
    logic    tabu;
    status_e status;
  } verdict_t;

  // Private copy of the table and counters
  bit                     live       [TABLE_DEPTH];
  logic [31:0]            expiry_mem [TABLE_DEPTH];
  logic [31:0]            iter;
  logic [LFSR_W-1:0]      lfsr;
  logic [TENURE_W-1:0]    tenure_lo;
  logic [TENURE_W-1:0]    tenure_hi;
  logic [WEEKS_CFG_W-1:0] weeks_cfg;
  logic [PLAYERS_CFG_W-1:0] players_cfg;

  verdict_t owed [$];

  // Apply one move to the private table and return the answer it should get
  function automatic verdict_t apply_move(input logic [ACTION_W-1:0] act,
                                          input logic [WEEK_W-1:0] wk,
                                          input logic [PLAYER_W-1:0] pa,
                                          input logic [PLAYER_W-1:0] pb);
    verdict_t            v;
    int                  week_limit;
    int                  player_limit;
    logic [PLAYER_W-1:0] lo;
    logic [PLAYER_W-1:0] hi;
    logic [13:0]         slot;
    logic [TENURE_W-1:0] spread;
    logic [31:0]         draw;
    v.tabu       = 1'b0;
    v.status     = ST_OK;
    week_limit   = (weeks_cfg > WEEKS) ? WEEKS : int'(weeks_cfg);
    player_limit = (players_cfg > PLAYERS) ? PLAYERS : int'(players_cfg);
    if (act <= ACT_CLR_WEEK) begin
      if (int'(wk) >= week_limit) begin
        v.status = ST_WEEK;
      end else if (act == ACT_CLR_WEEK) begin
        for (int i = 0; i < WEEK_SPAN; i++) live[{wk, 10'(i)}] = 1'b0;
      end else if (int'(pa) >= player_limit || int'(pb) >= player_limit) begin
        v.status = ST_PLAYER;
      end else begin
        lo   = (pa < pb) ? pa : pb;
        hi   = (pa < pb) ? pb : pa;
        slot = {wk, lo, hi};
        if (act == ACT_ADD) begin
          if (tenure_lo > tenure_hi) begin
            v.status = ST_TENURE;
          end else begin
            // advance the random word, then draw below the spread
            lfsr   = {1'b0, lfsr[LFSR_W-1:1]} ^ (lfsr[0] ? LFSR_TAPS : '0);
            spread = tenure_hi - tenure_lo;
            draw   = (spread == '0) ? 32'd0 : lfsr % {16'd0, spread};
            expiry_mem[slot] = iter + {16'd0, tenure_lo} + draw;
            live[slot]       = 1'b1;
          end
        end else begin
          v.tabu = live[slot] && (iter < expiry_mem[slot]);
        end
      end
    end else if (act == ACT_CLR_ALL) begin
      for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
    end else if (act == ACT_TICK) begin
      iter = iter + 32'd1;
    end
    return v;
  endfunction

  // Track registers, predict accepted items, compare accepted results
  always @(posedge clk_i or negedge rst_ni) begin
    verdict_t want;
    if (!rst_ni) begin
      for (int i = 0; i < TABLE_DEPTH; i++) live[i] = 1'b0;
      iter        = '0;
      lfsr        = LFSR_SEED;
      tenure_lo   = TENURE_LOW_RST;
      tenure_hi   = TENURE_HIGH_RST;
      weeks_cfg   = WEEKS_RST;
      players_cfg = PLAYERS_RST;
      owed.delete();
      errors_o    = 0;
      pending_o   = 0;
      checked_o   = 0;
      hits_o      = 0;
      rejects_o   = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TENURE_LOW:  tenure_lo = cfg_data_i[TENURE_W-1:0];
          CFG_TENURE_HIGH: tenure_hi = cfg_data_i[TENURE_W-1:0];
          CFG_WEEKS:       weeks_cfg = cfg_data_i[WEEKS_CFG_W-1:0];
          CFG_PLAYERS:     players_cfg = cfg_data_i[PLAYERS_CFG_W-1:0];
          default: ;
        endcase
      end
      // check the result first: it belongs to an older item
      if (rsp.valid && rsp.ready) begin
        checked_o++;
        if (owed.size() == 0) begin
          errors_o++;
          $display("%0t: result with nothing pending, got tabu %0b status %0d",
                   $time, rsp.pair_is_tabu, rsp.status);
        end else begin
          want = owed.pop_front();
          if (rsp.pair_is_tabu !== want.tabu) begin
            errors_o++;
            $display("%0t: tabu flag mismatch, expected %0b, actual %0b",
                     $time, want.tabu, rsp.pair_is_tabu);
          end
          if (rsp.status !== want.status) begin
            errors_o++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, rsp.status);
          end
        end
      end
      if (req.valid && req.ready) begin
        want = apply_move(req.action, req.week, req.player_a, req.player_b);
        owed.push_back(want);
        if (want.status != ST_OK) rejects_o++;
        if (want.tabu) hits_o++;
      end
      pending_o = owed.size();
    end
  end

endmodule

// File: test/pair_tabu_expiry_table_test.sv
`timescale 1ns / 1ps

module pair_tabu_expiry_table_test;
  import ptet_pkg::*;

  typedef struct packed {
    logic [ACTION_W-1:0] act;
    logic [WEEK_W-1:0]   wk;
    logic [PLAYER_W-1:0] pa;
    logic [PLAYER_W-1:0] pb;
  } tabu_move_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned errors;
  int unsigned pending;
  int unsigned checked;
  int unsigned hits;
  int unsigned rejects;

  bit         calm = 1'b0;
  int         week_lim;
  int         player_lim;
  int         moves_sent;
  int         settings_run;
  tabu_move_t recent [$];

  ptet_req_if req_if ();
  ptet_rsp_if rsp_if ();

  pair_tabu_expiry_table uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  ptet_tabu_checker tabu_check (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req        (req_if),
    .rsp        (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .errors_o   (errors),
    .pending_o  (pending),
    .checked_o  (checked),
    .hits_o     (hits),
    .rejects_o  (rejects)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Result side: stall a random number of cycles before each item
  initial begin
    int stall;
    rsp_if.ready = 1'b0;
    @(negedge clk_i);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        rsp_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      rsp_if.ready <= 1'b1;
      do @(posedge clk_i); while (!rsp_if.valid);
      @(negedge clk_i);
    end
  end

  // Offer one move after a random gap and hold it until taken
  task automatic send_move(input tabu_move_t m);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid    <= 1'b1;
    req_if.action   <= m.act;
    req_if.week     <= m.wk;
    req_if.player_a <= m.pa;
    req_if.player_b <= m.pb;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    if (m.act == ACT_ADD) begin
      recent.push_back(m);
      if (recent.size() > 12) void'(recent.pop_front());
    end
    moves_sent++;
    if (moves_sent % 32 == 0) calm = ($urandom_range(0, 3) == 0);
  endtask

  // Hold off new items until every predicted result is back
  task automatic drain_results();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    @(negedge clk_i);
  endtask

  // Write all four registers while the block is idle
  task automatic load_settings(input logic [TENURE_W-1:0] lo,
                               input logic [TENURE_W-1:0] hi,
                               input logic [WEEKS_CFG_W-1:0] wk,
                               input logic [PLAYERS_CFG_W-1:0] pl);
    drain_results();
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_TENURE_LOW;
    cfg_data <= lo;
    @(negedge clk_i);
    cfg_idx  <= CFG_TENURE_HIGH;
    cfg_data <= hi;
    @(negedge clk_i);
    cfg_idx  <= CFG_WEEKS;
    cfg_data <= {11'd0, wk};
    @(negedge clk_i);
    cfg_idx  <= CFG_PLAYERS;
    cfg_data <= {10'd0, pl};
    @(negedge clk_i);
    cfg_we   <= 1'b0;
    week_lim   = (wk > MAX_WEEKS_DEF) ? MAX_WEEKS_DEF : int'(wk);
    player_lim = (pl > MAX_PLAYERS_DEF) ? MAX_PLAYERS_DEF : int'(pl);
    settings_run++;
  endtask

  // Mostly in-range moves, queries aimed at recent adds; the rest is noise
  function automatic tabu_move_t pick_move();
    tabu_move_t m;
    tabu_move_t old;
    int         roll;
    m.act = 3'($urandom_range(0, 7));
    m.wk  = 4'($urandom_range(0, 15));
    m.pa  = 5'($urandom_range(0, 31));
    m.pb  = 5'($urandom_range(0, 31));
    if ($urandom_range(0, 99) < 75) begin
      if (week_lim != 0) m.wk = 4'($urandom_range(0, week_lim - 1));
      if (player_lim != 0) begin
        m.pa = 5'($urandom_range(0, player_lim - 1));
        m.pb = 5'($urandom_range(0, player_lim - 1));
      end
      roll = $urandom_range(0, 99);
      if (roll < 35) begin
        m.act = ACT_ADD;
      end else if (roll < 73) begin
        m.act = ACT_QUERY;
        if (recent.size() != 0 && $urandom_range(0, 2) != 0) begin
          old  = recent[$urandom_range(0, recent.size() - 1)];
          m.wk = old.wk;
          m.pa = old.act[0] ? old.pb : old.pa;
          m.pb = old.act[0] ? old.pa : old.pb;
          if ($urandom_range(0, 1) != 0) begin
            m.pa = old.pb;
            m.pb = old.pa;
          end
        end
      end else if (roll < 93) begin
        m.act = ACT_TICK;
      end else if (roll < 97) begin
        m.act = ACT_CLR_WEEK;
      end else if (roll < 98) begin
        m.act = ACT_CLR_ALL;
      end else begin
        m.act = 3'($urandom_range(5, 7));
      end
    end
    return m;
  endfunction

  // Random moves under the current settings, with an occasional full drain
  task automatic run_random(input int count);
    for (int k = 0; k < count; k++) begin
      send_move(pick_move());
      if (k % 97 == 96) drain_results();
    end
  endtask

  // Stimulus and verdict
  initial begin
    rst_ni          = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = CFG_TENURE_LOW;
    cfg_data        = '0;
    req_if.valid    = 1'b0;
    req_if.action   = ACT_ADD;
    req_if.week     = '0;
    req_if.player_a = '0;
    req_if.player_b = '0;
    moves_sent      = 0;
    settings_run    = 0;
    week_lim        = MAX_WEEKS_DEF;
    player_lim      = MAX_PLAYERS_DEF;
    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Fixed tenure of two so expiry lands on a known tick
    load_settings(16'd2, 16'd2, 5'd16, 6'd32);
    send_move('{ACT_QUERY, 4'd0, 5'd0, 5'd0});
    send_move('{ACT_ADD, 4'd0, 5'd0, 5'd0});
    send_move('{ACT_QUERY, 4'd0, 5'd0, 5'd0});
    send_move('{ACT_ADD, 4'd15, 5'd31, 5'd30});
    send_move('{ACT_QUERY, 4'd15, 5'd30, 5'd31});
    send_move('{ACT_TICK, 4'd0, 5'd0, 5'd0});
    send_move('{ACT_QUERY, 4'd15, 5'd31, 5'd30});
    send_move('{ACT_TICK, 4'd9, 5'd17, 5'd4});
    send_move('{ACT_QUERY, 4'd15, 5'd30, 5'd31});
    send_move('{ACT_ADD, 4'd3, 5'd5, 5'd9});
    send_move('{ACT_QUERY, 4'd3, 5'd9, 5'd5});
    send_move('{ACT_CLR_WEEK, 4'd3, 5'd31, 5'd31});
    send_move('{ACT_QUERY, 4'd3, 5'd9, 5'd5});
    send_move('{ACT_ADD, 4'd7, 5'd1, 5'd2});
    send_move('{ACT_CLR_ALL, 4'd7, 5'd1, 5'd2});
    send_move('{ACT_QUERY, 4'd7, 5'd2, 5'd1});
    send_move('{3'd5, 4'd15, 5'd31, 5'd31});
    send_move('{3'd6, 4'd0, 5'd0, 5'd0});
    send_move('{3'd7, 4'd10, 5'd21, 5'd10});
    send_move('{ACT_QUERY, 4'd0, 5'd31, 5'd31});
    run_random(100);

    // Reset values, then zero spread on a single week and player
    load_settings(TENURE_LOW_RST, TENURE_HIGH_RST, WEEKS_RST, PLAYERS_RST);
    run_random(180);
    load_settings(16'd0, 16'd0, 5'd1, 6'd1);
    run_random(100);

    // Largest tenure on partial ranges, then low above high
    load_settings(16'hFFFF, 16'hFFFF, 5'd8, 6'd12);
    run_random(100);
    load_settings(16'd10, 16'd5, 5'd16, 6'd32);
    run_random(80);

    // Short tenures so entries expire often
    load_settings(16'd1, 16'd3, 5'd3, 6'd5);
    run_random(200);

    // Widest spread with nothing in range, then counts above the table size
    load_settings(16'd0, 16'hFFFF, 5'd0, 6'd0);
    run_random(40);
    load_settings(16'd2, 16'd9, 5'd31, 6'd63);
    run_random(200);

    drain_results();
    repeat (600) @(posedge clk_i);

    $display("Checked %0d results across %0d register settings, %0d of them tabu hits,",
             checked, settings_run, hits);
    $display("%0d rejected for range or tenure; random idling and back-to-back bursts mixed.",
             rejects);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/ptet_pkg.sv
src/ptet_req_if.sv
src/ptet_rsp_if.sv
src/ptet_mod.sv
src/ptet_dp.sv
src/ptet_ctrl.sv
src/pair_tabu_expiry_table.sv
test/ptet_tabu_checker.sv
test/pair_tabu_expiry_table_test.sv
